[sv/rrtl_pkg.sv]
// Shared types, constants and helper functions of the rounded-rectangle track locator.
package rrtl_pkg;

	localparam int CW   = 16;            // coordinate width, Q3.12
	localparam int OW   = 17;            // offset width, difference of two coordinates
	localparam int D2W  = 34;            // squared offset length, Q.24
	localparam int RTW  = 17;            // square root width
	localparam int RMW  = 19;            // square root partial remainder
	localparam int QW   = 15;            // normal quotient magnitude width
	localparam int DRW  = 17;            // divider partial remainder
	localparam int CXW  = 35;            // CORDIC vector width
	localparam int CZW  = 33;            // CORDIC angle width
	localparam int ATW  = 31;            // angle table entry width
	localparam int CQW  = 15;            // corner arc length width
	localparam int POSW = 22;            // signed working width of track position
	localparam int PW   = 18;            // track position output width
	localparam int SQRT_CELLS = D2W / 2;
	localparam int DIV_CELLS  = QW;
	localparam int CORDIC_PRESHIFT = 14;

	// Offsets at or above this magnitude can never count as negligible.
	localparam logic [6:0]  SMALL_LIMIT = 7'd93;
	localparam logic [19:0] ZERO_SCALE  = 20'd1000000;

	localparam logic [2:0] REG_LEFT   = 3'd0;
	localparam logic [2:0] REG_RIGHT  = 3'd1;
	localparam logic [2:0] REG_BOTTOM = 3'd2;
	localparam logic [2:0] REG_TOP    = 3'd3;
	localparam logic [2:0] REG_ARC    = 3'd4;

	localparam logic [3:0] REGION_RIGHT       = 4'd0;
	localparam logic [3:0] REGION_LOWER_RIGHT = 4'd1;
	localparam logic [3:0] REGION_BOTTOM      = 4'd2;
	localparam logic [3:0] REGION_LOWER_LEFT  = 4'd3;
	localparam logic [3:0] REGION_LEFT        = 4'd4;
	localparam logic [3:0] REGION_UPPER_LEFT  = 4'd5;
	localparam logic [3:0] REGION_TOP         = 4'd6;
	localparam logic [3:0] REGION_UPPER_RIGHT = 4'd7;
	localparam logic [3:0] REGION_NONE        = 4'd8;

	typedef struct packed {
		logic signed [OW-1:0] dx;
		logic signed [OW-1:0] dy;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic                 zero;
		logic                 zx;
		logic                 zy;
		logic [RTW-1:0]       len;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
	} side_t;

	typedef struct packed {
		logic [RMW-1:0] rem;
		logic [RTW-1:0] root;
		logic [D2W-1:0] rad;
	} sqrt_t;

	typedef struct packed {
		logic [DRW-1:0] rem;
		logic [QW-1:0]  num;
		logic [QW-1:0]  quo;
	} div_t;

	typedef struct packed {
		logic signed [CXW-1:0] x;
		logic signed [CXW-1:0] y;
		logic signed [CZW-1:0] z;
	} cordic_t;

	function automatic logic signed [CW-1:0] clamp_coord(logic signed [CW-1:0] v,
			logic signed [CW-1:0] a, logic signed [CW-1:0] b);
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a > b) ? a : b;
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [CW-1:0] offset_mag(logic signed [OW-1:0] v);
		logic signed [OW-1:0] m;
		m = (v < 0) ? -v : v;
		return m[CW-1:0];
	endfunction

	// Quarter-turn arctangent table in units of 2^-30 of a quarter turn.
	function automatic logic [ATW-1:0] atan_quarter(int i);
		logic [ATW-1:0] r;
		unique case (i)
			0:  r = 31'd536870912;
			1:  r = 31'd316933406;
			2:  r = 31'd167458904;
			3:  r = 31'd85004576;
			4:  r = 31'd42667282;
			5:  r = 31'd21354345;
			6:  r = 31'd10679855;
			7:  r = 31'd5340311;
			8:  r = 31'd2670178;
			9:  r = 31'd1335089;
			10: r = 31'd667545;
			11: r = 31'd333772;
			12: r = 31'd166886;
			13: r = 31'd83443;
			14: r = 31'd41722;
			15: r = 31'd20861;
			16: r = 31'd10430;
			17: r = 31'd5215;
			18: r = 31'd2608;
			19: r = 31'd1304;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[sv/rrtl_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
module rrtl_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  rrtl_pkg::sqrt_t d,
	output rrtl_pkg::sqrt_t q
);
	import rrtl_pkg::*;

	logic [RMW+1:0] cur;
	logic [RMW+1:0] trial;
	logic           ge;
	sqrt_t          nxt;

	always_comb begin
		cur   = {d.rem, d.rad[D2W-1 -: 2]};
		trial = {{(RMW-RTW){1'b0}}, d.root, 2'b01};
		ge    = (cur >= trial);
		nxt.rem  = ge ? RMW'(cur - trial) : RMW'(cur);
		nxt.root = {d.root[RTW-2:0], ge};
		nxt.rad  = {d.rad[D2W-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[sv/rrtl_div_cell.sv]
// One quotient-bit cell of the pipelined restoring divider for the normal.
module rrtl_div_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rrtl_pkg::RTW-1:0]   divisor,
	input  rrtl_pkg::div_t             d,
	output rrtl_pkg::div_t             q
);
	import rrtl_pkg::*;

	logic [DRW:0] cur;
	logic         ge;
	div_t         nxt;

	always_comb begin
		cur = {d.rem, d.num[QW-1]};
		ge  = (cur >= {{(DRW+1-RTW){1'b0}}, divisor});
		nxt.rem = ge ? DRW'(cur - {{(DRW+1-RTW){1'b0}}, divisor}) : DRW'(cur);
		nxt.num = {d.num[QW-2:0], 1'b0};
		nxt.quo = {d.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[sv/rrtl_cordic_cell.sv]
// One vectoring rotation cell of the corner-angle CORDIC.
module rrtl_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  rrtl_pkg::cordic_t d,
	output rrtl_pkg::cordic_t q
);
	import rrtl_pkg::*;

	logic signed [CXW-1:0] xs;
	logic signed [CXW-1:0] ys;
	logic signed [CZW-1:0] ang;
	cordic_t               nxt;

	always_comb begin
		xs  = d.x >>> STEP;
		// The residual is shifted on its magnitude, so it truncates toward zero.
		ys  = (d.y >= 0) ? (d.y >>> STEP) : -((-d.y) >>> STEP);
		ang = $signed({{(CZW-ATW){1'b0}}, atan_quarter(STEP)});
		nxt = d;
		priority if (d.y > 0) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ang;
		end else if (d.y < 0) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ang;
		end else begin
			// A residual of exactly zero leaves the vector where it is.
			nxt = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[sv/rounded_rect_track_locator.sv]
// Top level of the rounded-rectangle track locator: clamp, select, root, divide, CORDIC.
//
//  Channel  Signals                                   Direction  Moves
//  config   cfg_write cfg_index cfg_data              in         one register write
//  point    point_valid point_ready point_x point_y   in         one query point
//  result   result_valid result_ready track_position  out        one track location
//           clearance normal_x normal_y region
//
// One point is taken per cycle while no result waits to be taken; each transfer passes
// through the chain of square-root, divider and CORDIC cells.
// Reset clears the valid bits and loads the default rectangle; no clearing pass is needed.
// The whole chain advances together and holds while a result waits to be taken.
module rounded_rect_track_locator #(
	parameter int CORDIC_STEPS = 14,
	parameter int FRAC_BITS    = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               point_valid,
	output logic               point_ready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [17:0]        track_position,
	output logic [15:0]        clearance,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic [3:0]         region
);
	import rrtl_pkg::*;

	localparam int NST = 3 + SQRT_CELLS + DIV_CELLS + CORDIC_STEPS + 2;
	localparam int FW  = FRAC_BITS + 1;
	localparam int MW  = CQW + FW;

	// Configuration registers.
	logic signed [CW-1:0] left_q, right_q, bottom_q, top_q;
	logic [CQW-1:0]       arc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= -16'sd2458;
			right_q  <= 16'sd2458;
			bottom_q <= -16'sd2294;
			top_q    <= 16'sd2294;
			arc_q    <= 15'd1287;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_ARC:    arc_q    <= cfg_data[CQW-1:0];
				default: ;
			endcase
		end
	end

	// Stall control: every stage moves when the output register is free or its result is taken.
	logic           adv;
	logic [NST-1:0] vld_q;

	assign adv          = !vld_q[NST-1] || result_ready;
	assign point_ready  = adv;
	assign result_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], point_valid};
		end
	end

	// Stage 1: clamp onto the four sides and form the offsets.
	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];
	logic signed [CW-1:0] cx_s1 [4];
	logic signed [CW-1:0] cy_s1 [4];
	logic signed [OW-1:0] ex_s1 [4];
	logic signed [OW-1:0] ey_s1 [4];

	always_comb begin
		cx[0] = right_q;
		cy[0] = clamp_coord(point_y, top_q, bottom_q);
		cx[1] = clamp_coord(point_x, right_q, left_q);
		cy[1] = bottom_q;
		cx[2] = left_q;
		cy[2] = clamp_coord(point_y, bottom_q, top_q);
		cx[3] = clamp_coord(point_x, left_q, right_q);
		cy[3] = top_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				cx_s1[k] <= cx[k];
				cy_s1[k] <= cy[k];
				ex_s1[k] <= $signed({cx[k][CW-1], cx[k]}) - $signed({point_x[CW-1], point_x});
				ey_s1[k] <= $signed({cy[k][CW-1], cy[k]}) - $signed({point_y[CW-1], point_y});
			end
		end
	end

	// Stage 2: squared lengths, and small squares for the negligible-component test.
	logic [D2W-1:0]       e2_s2 [4];
	logic signed [CW-1:0] cx_s2 [4];
	logic signed [CW-1:0] cy_s2 [4];
	logic signed [OW-1:0] ex_s2 [4];
	logic signed [OW-1:0] ey_s2 [4];
	logic [13:0]          sqx_s2 [4];
	logic [13:0]          sqy_s2 [4];
	logic                 bigx_s2 [4];
	logic                 bigy_s2 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				logic signed [2*OW-1:0] px2;
				logic signed [2*OW-1:0] py2;
				logic [CW-1:0]          ax;
				logic [CW-1:0]          ay;
				px2 = ex_s1[k] * ex_s1[k];
				py2 = ey_s1[k] * ey_s1[k];
				ax  = offset_mag(ex_s1[k]);
				ay  = offset_mag(ey_s1[k]);
				e2_s2[k]   <= D2W'($unsigned(px2)) + D2W'($unsigned(py2));
				cx_s2[k]   <= cx_s1[k];
				cy_s2[k]   <= cy_s1[k];
				ex_s2[k]   <= ex_s1[k];
				ey_s2[k]   <= ey_s1[k];
				sqx_s2[k]  <= ax[6:0] * ax[6:0];
				sqy_s2[k]  <= ay[6:0] * ay[6:0];
				bigx_s2[k] <= (ax >= {{(CW-7){1'b0}}, SMALL_LIMIT});
				bigy_s2[k] <= (ay >= {{(CW-7){1'b0}}, SMALL_LIMIT});
			end
		end
	end

	// Stage 3: nearest side; strict compares keep the earlier side on a tie.
	logic [1:0]           b01, b23, best;
	logic [D2W-1:0]       d2_s3;
	logic signed [OW-1:0] dx_s3, dy_s3;
	logic signed [CW-1:0] bx_s3, by_s3;
	logic [13:0]          sqx_s3, sqy_s3;
	logic                 bigx_s3, bigy_s3;

	always_comb begin
		b01  = (e2_s2[1] < e2_s2[0]) ? 2'd1 : 2'd0;
		b23  = (e2_s2[3] < e2_s2[2]) ? 2'd3 : 2'd2;
		best = (e2_s2[b23] < e2_s2[b01]) ? b23 : b01;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s3   <= e2_s2[best];
			dx_s3   <= ex_s2[best];
			dy_s3   <= ey_s2[best];
			bx_s3   <= cx_s2[best];
			by_s3   <= cy_s2[best];
			sqx_s3  <= sqx_s2[best];
			sqy_s3  <= sqy_s2[best];
			bigx_s3 <= bigx_s2[best];
			bigy_s3 <= bigy_s2[best];
		end
	end

	// Square-root chain.
	side_t side_in;
	sqrt_t sq_in;
	sqrt_t sqo [SQRT_CELLS];
	side_t sa  [SQRT_CELLS];

	always_comb begin
		side_in      = '0;
		side_in.dx   = dx_s3;
		side_in.dy   = dy_s3;
		side_in.bx   = bx_s3;
		side_in.by   = by_s3;
		side_in.zero = (d2_s3 == '0);
		side_in.zx   = !bigx_s3 && ((D2W'(sqx_s3) * D2W'(ZERO_SCALE)) < d2_s3);
		side_in.zy   = !bigy_s3 && ((D2W'(sqy_s3) * D2W'(ZERO_SCALE)) < d2_s3);
		sq_in.rem    = '0;
		sq_in.root   = '0;
		sq_in.rad    = d2_s3;
	end

	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		if (j == 0) begin : g_first
			rrtl_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sq_in), .q(sqo[j]));
		end else begin : g_next
			rrtl_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sqo[j-1]), .q(sqo[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sa[0] <= side_in;
			for (int j = 1; j < SQRT_CELLS; j++) begin
				sa[j] <= sa[j-1];
			end
		end
	end

	// Divider chain for both normal components.
	side_t mb;
	div_t  dvx_in, dvy_in;
	div_t  dxo [DIV_CELLS];
	div_t  dyo [DIV_CELLS];
	side_t sb  [DIV_CELLS];

	always_comb begin
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		mb     = sa[SQRT_CELLS-1];
		mb.len = sqo[SQRT_CELLS-1].root;
		ax     = offset_mag(mb.dx);
		ay     = offset_mag(mb.dy);
		dvx_in.rem = {{(DRW-CW+1){1'b0}}, ax[CW-1:1]};
		dvx_in.num = {ax[0], {(QW-1){1'b0}}};
		dvx_in.quo = '0;
		dvy_in.rem = {{(DRW-CW+1){1'b0}}, ay[CW-1:1]};
		dvy_in.num = {ay[0], {(QW-1){1'b0}}};
		dvy_in.quo = '0;
	end

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		if (j == 0) begin : g_first
			rrtl_div_cell u_cellx (.clk(clk), .en(adv), .divisor(mb.len), .d(dvx_in),
				.q(dxo[j]));
			rrtl_div_cell u_celly (.clk(clk), .en(adv), .divisor(mb.len), .d(dvy_in),
				.q(dyo[j]));
		end else begin : g_next
			rrtl_div_cell u_cellx (.clk(clk), .en(adv), .divisor(sb[j-1].len), .d(dxo[j-1]),
				.q(dxo[j]));
			rrtl_div_cell u_celly (.clk(clk), .en(adv), .divisor(sb[j-1].len), .d(dyo[j-1]),
				.q(dyo[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb[0] <= mb;
			for (int j = 1; j < DIV_CELLS; j++) begin
				sb[j] <= sb[j-1];
			end
		end
	end

	// CORDIC chain for the corner angle.
	side_t   mc;
	cordic_t co_in;
	cordic_t coo [CORDIC_STEPS];
	side_t   sc  [CORDIC_STEPS];

	always_comb begin
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		qx = $signed({1'b0, dxo[DIV_CELLS-1].quo});
		qy = $signed({1'b0, dyo[DIV_CELLS-1].quo});
		mc    = sb[DIV_CELLS-1];
		mc.nx = (mc.dx < 0) ? -qx : qx;
		mc.ny = (mc.dy < 0) ? -qy : qy;
		co_in.x = $signed({{(CXW-CW-CORDIC_PRESHIFT){1'b0}}, offset_mag(mc.dx),
			{CORDIC_PRESHIFT{1'b0}}});
		co_in.y = $signed({{(CXW-CW-CORDIC_PRESHIFT){1'b0}}, offset_mag(mc.dy),
			{CORDIC_PRESHIFT{1'b0}}});
		co_in.z = '0;
	end

	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
		if (j == 0) begin : g_first
			rrtl_cordic_cell #(.STEP(j)) u_cell (.clk(clk), .en(adv), .d(co_in), .q(coo[j]));
		end else begin : g_next
			rrtl_cordic_cell #(.STEP(j)) u_cell (.clk(clk), .en(adv), .d(coo[j-1]),
				.q(coo[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc[0] <= mc;
			for (int j = 1; j < CORDIC_STEPS; j++) begin
				sc[j] <= sc[j-1];
			end
		end
	end

	// Final stage 1: region, base position and angle fraction.
	side_t                  md;
	logic signed [CZW-1:0]  zr;
	logic [31:0]            zc;
	logic [31:0]            zs;
	logic [FW-1:0]          fv;
	logic [FW-1:0]          one;
	logic signed [POSW-1:0] hh, ww, qq, tt, bb, rr, ll, bxw, byw;
	logic [3:0]             rg;
	logic signed [POSW-1:0] base;
	logic                   corner;
	logic [FW-1:0]          fsel;

	logic [3:0]             rg_f1;
	logic signed [POSW-1:0] base_f1;
	logic                   corner_f1;
	logic [FW-1:0]          fs_f1;
	logic                   zero_f1;
	logic [RTW-1:0]         len_f1;
	logic signed [CW-1:0]   nx_f1, ny_f1;

	always_comb begin
		md  = sc[CORDIC_STEPS-1];
		zr  = coo[CORDIC_STEPS-1].z;
		priority if (zr < 0) begin
			zc = '0;
		end else if (zr > $signed(CZW'(33'd1 << 30))) begin
			zc = 32'd1 << 30;
		end else begin
			zc = zr[31:0];
		end
		zs  = zc + (32'd1 << (29 - FRAC_BITS));
		fv  = FW'(zs >> (30 - FRAC_BITS));
		one = FW'(1) << FRAC_BITS;
		tt  = POSW'(top_q);
		bb  = POSW'(bottom_q);
		rr  = POSW'(right_q);
		ll  = POSW'(left_q);
		bxw = POSW'(md.bx);
		byw = POSW'(md.by);
		qq  = $signed({{(POSW-CQW){1'b0}}, arc_q});
		hh  = tt - bb;
		ww  = rr - ll;
		corner = 1'b0;
		fsel   = fv;
		priority if (md.zy) begin
			if (md.dx < 0) begin
				rg   = REGION_RIGHT;
				base = tt - byw;
			end else begin
				rg   = REGION_LEFT;
				base = hh + ww + (qq <<< 1) + (byw - bb);
			end
		end else if (md.zx) begin
			if (md.dy > 0) begin
				rg   = REGION_BOTTOM;
				base = hh + qq + (rr - bxw);
			end else begin
				rg   = REGION_TOP;
				base = (hh <<< 1) + ww + (qq <<< 1) + qq + (bxw - ll);
			end
		end else begin
			corner = 1'b1;
			priority if (md.dx < 0 && md.dy > 0) begin
				rg   = REGION_LOWER_RIGHT;
				base = hh;
			end else if (md.dx > 0 && md.dy > 0) begin
				rg   = REGION_LOWER_LEFT;
				base = hh + ww + qq;
				fsel = one - fv;
			end else if (md.dx > 0) begin
				rg   = REGION_UPPER_LEFT;
				base = (hh <<< 1) + ww + (qq <<< 1);
			end else begin
				rg   = REGION_UPPER_RIGHT;
				base = (hh <<< 1) + (ww <<< 1) + (qq <<< 1) + qq;
				fsel = one - fv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_f1     <= rg;
			base_f1   <= base;
			corner_f1 <= corner;
			fs_f1     <= fsel;
			zero_f1   <= md.zero;
			len_f1    <= md.len;
			nx_f1     <= md.nx;
			ny_f1     <= md.ny;
		end
	end

	// Final stage 2: corner term, saturation and the output register.
	logic [MW-1:0]          prod;
	logic [MW-1:0]          term;
	logic signed [POSW-1:0] pos;

	always_comb begin
		prod = MW'(arc_q) * MW'(fs_f1);
		term = (prod + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		pos  = base_f1 + (corner_f1 ? $signed({{(POSW-CQW-1){1'b0}}, term[CQW:0]})
			: POSW'(0));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_f1) begin
				track_position <= '0;
				clearance      <= '0;
				normal_x       <= '0;
				normal_y       <= '0;
				region         <= REGION_NONE;
			end else begin
				priority if (pos < 0) begin
					track_position <= '0;
				end else if (pos > $signed(POSW'({PW{1'b1}}))) begin
					track_position <= '1;
				end else begin
					track_position <= pos[PW-1:0];
				end
				clearance <= len_f1[RTW-1] ? 16'hFFFF : len_f1[15:0];
				normal_x  <= nx_f1;
				normal_y  <= ny_f1;
				region    <= rg_f1;
			end
		end
	end

endmodule
